>>> hw/rtl/image_upscale_2x_midpoint_assert.svh
// Assertion macros shared by the 2x upscaler RTL.
// No dependencies; included by modules that carry checks.
`ifndef IMAGE_UPSCALE_2X_MIDPOINT_ASSERT_SVH
`define IMAGE_UPSCALE_2X_MIDPOINT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define IU2X_ASSERT_IMP(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("iu2x: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define IU2X_ASSERT_NXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("iu2x: next-cycle check failed");

`endif

>>> hw/rtl/iu2x_pkg.sv
// Shared types, sizes and helpers for the 2x midpoint upscaler.
// No dependencies.
package iu2x_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4096;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = $clog2(MAX_HEIGHT);
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int OUT_COL_W    = 11;
  localparam int OUT_ROW_W    = 13;
  localparam int CHAN_W       = 8;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 13;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // result slots, in emission order
  localparam int SLOT_CENTRE = 0;
  localparam int SLOT_VERT   = 1;
  localparam int SLOT_HORIZ  = 2;
  localparam int SLOT_ORIG   = 3;
  localparam int NUM_SLOTS   = 4;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // input register contents
  typedef struct packed {
    logic             valid;
    pixel_t           pix;
    pixel_t           left;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } front_t;

  // up to four results of one item
  typedef struct packed {
    logic                 valid;
    logic [NUM_SLOTS-1:0] mask;
    pixel_t               centre;
    pixel_t               vert;
    pixel_t               horiz;
    pixel_t               orig;
    logic [OUT_ROW_W-1:0] row_even;
    logic [OUT_COL_W-1:0] col_even;
  } run_t;

  function automatic logic [CHAN_W-1:0] avg_chan(logic [CHAN_W-1:0] a,
                                                 logic [CHAN_W-1:0] b);
    logic [CHAN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CHAN_W:1];
  endfunction

  function automatic pixel_t avg_pixel(pixel_t a, pixel_t b);
    pixel_t r;
    r.red   = avg_chan(a.red, b.red);
    r.green = avg_chan(a.green, b.green);
    r.blue  = avg_chan(a.blue, b.blue);
    return r;
  endfunction

endpackage

>>> hw/rtl/iu2x_ram.sv
// Generic single-port RAM, read-before-write, registered read data.
// No dependencies.
module iu2x_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem[addr];
      if (we) begin
        mem[addr] <= wdata;
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/iu2x_front.sv
// Input register, position counters, left pixel and line store port.
// Depends on iu2x_pkg.
module iu2x_front (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [iu2x_pkg::CHAN_W-1:0]            in_red,
  input  logic [iu2x_pkg::CHAN_W-1:0]            in_green,
  input  logic [iu2x_pkg::CHAN_W-1:0]            in_blue,
  input  logic [iu2x_pkg::WIDTH_REG_W-1:0]       width_eff,
  input  logic [iu2x_pkg::HEIGHT_REG_W-1:0]      height_eff,
  input  logic                                   front_take,
  output logic                                   ram_en,
  output logic [iu2x_pkg::COL_W-1:0]             ram_addr,
  output iu2x_pkg::pixel_t                       ram_wdata,
  output iu2x_pkg::front_t                       front
);

  iu2x_pkg::front_t                     front_r;
  iu2x_pkg::pixel_t                     left_r;
  iu2x_pkg::pixel_t                     cur;
  logic [iu2x_pkg::COL_W-1:0]           col_r, col_nxt;
  logic [iu2x_pkg::ROW_W-1:0]           row_r, row_nxt;
  logic [iu2x_pkg::WIDTH_REG_W-1:0]     col_inc;
  logic [iu2x_pkg::HEIGHT_REG_W-1:0]    row_inc;
  logic                                 accept;

  assign cur.red   = in_red;
  assign cur.green = in_green;
  assign cur.blue  = in_blue;

  assign in_stall = front_r.valid && !front_take;
  assign accept   = in_valid && !in_stall;

  assign col_inc = {1'b0, col_r} + iu2x_pkg::WIDTH_REG_W'(1);
  assign row_inc = {1'b0, row_r} + iu2x_pkg::HEIGHT_REG_W'(1);

  // a counter at or beyond the (possibly shrunk) size wraps on advance
  always_comb begin
    col_nxt = col_inc[iu2x_pkg::COL_W-1:0];
    row_nxt = row_r;
    if (col_inc >= width_eff) begin
      col_nxt = '0;
      if (row_inc >= height_eff) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_inc[iu2x_pkg::ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
      col_r         <= '0;
      row_r         <= '0;
      left_r        <= '0;
    end else if (accept) begin
      front_r.valid <= 1'b1;
      front_r.pix   <= cur;
      front_r.left  <= left_r;
      front_r.col   <= col_r;
      front_r.row   <= row_r;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      left_r        <= cur;
    end else if (front_take) begin
      front_r.valid <= 1'b0;
    end
  end

  // row above is read and the new pixel written in the same access
  assign ram_en    = accept;
  assign ram_addr  = col_r;
  assign ram_wdata = cur;
  assign front     = front_r;

endmodule

>>> hw/rtl/iu2x_interp.sv
// Midpoint interpolation of one item: vertical, horizontal and centre averages.
// Depends on iu2x_pkg.
module iu2x_interp (
  input  logic              clk,
  input  logic              rst_n,
  input  iu2x_pkg::front_t  front,
  input  iu2x_pkg::pixel_t  above,
  input  logic              run_ready,
  output logic              front_take,
  output iu2x_pkg::run_t    run_in
);

  iu2x_pkg::pixel_t left_vavg_r;
  iu2x_pkg::pixel_t vavg;
  logic             has_top;
  logic             has_left;

  assign has_top  = (front.row != '0);
  assign has_left = (front.col != '0);

  assign vavg       = has_top ? iu2x_pkg::avg_pixel(above, front.pix) : '0;
  assign front_take = front.valid && run_ready;

  always_comb begin
    run_in.valid                        = front.valid;
    run_in.mask                         = '0;
    run_in.mask[iu2x_pkg::SLOT_CENTRE]  = has_top && has_left;
    run_in.mask[iu2x_pkg::SLOT_VERT]    = has_top;
    run_in.mask[iu2x_pkg::SLOT_HORIZ]   = has_left;
    run_in.mask[iu2x_pkg::SLOT_ORIG]    = 1'b1;
    run_in.centre                       = iu2x_pkg::avg_pixel(left_vavg_r, vavg);
    run_in.vert                         = vavg;
    run_in.horiz                        = iu2x_pkg::avg_pixel(front.left, front.pix);
    run_in.orig                         = front.pix;
    run_in.row_even                     = {front.row, 1'b0};
    run_in.col_even                     = {front.col, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_vavg_r <= '0;
    end else if (front_take) begin
      left_vavg_r <= vavg;
    end
  end

endmodule

>>> hw/rtl/iu2x_seq.sv
// Sequencer: holds an item's results, sends one per cycle unless stalled.
// Depends on iu2x_pkg and image_upscale_2x_midpoint_assert.svh.
`include "image_upscale_2x_midpoint_assert.svh"

module iu2x_seq (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  iu2x_pkg::run_t                       run_in,
  output logic                                 run_ready,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [iu2x_pkg::CHAN_W-1:0]          out_red,
  output logic [iu2x_pkg::CHAN_W-1:0]          out_green,
  output logic [iu2x_pkg::CHAN_W-1:0]          out_blue,
  output logic [iu2x_pkg::OUT_ROW_W-1:0]       out_row,
  output logic [iu2x_pkg::OUT_COL_W-1:0]       out_col,
  output logic                                 out_last_of_run
);

  iu2x_pkg::run_t                       run_r;
  logic [iu2x_pkg::NUM_SLOTS-1:0]       mask_r, mask_nxt, sel;
  logic                                 out_valid_r;
  logic                                 out_last_r;
  iu2x_pkg::pixel_t                     out_pix_r, pix_sel;
  logic [iu2x_pkg::OUT_ROW_W-1:0]       out_row_r, row_sel;
  logic [iu2x_pkg::OUT_COL_W-1:0]       out_col_r, col_sel;
  logic                                 out_free;
  logic                                 emit;
  logic                                 last;
  logic                                 load;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = run_r.valid && out_free;

  // lowest pending slot goes first
  always_comb begin
    sel     = '0;
    pix_sel = run_r.orig;
    row_sel = run_r.row_even;
    col_sel = run_r.col_even;
    priority if (mask_r[iu2x_pkg::SLOT_CENTRE]) begin
      sel[iu2x_pkg::SLOT_CENTRE] = 1'b1;
      pix_sel = run_r.centre;
      row_sel = run_r.row_even - iu2x_pkg::OUT_ROW_W'(1);
      col_sel = run_r.col_even - iu2x_pkg::OUT_COL_W'(1);
    end else if (mask_r[iu2x_pkg::SLOT_VERT]) begin
      sel[iu2x_pkg::SLOT_VERT] = 1'b1;
      pix_sel = run_r.vert;
      row_sel = run_r.row_even - iu2x_pkg::OUT_ROW_W'(1);
    end else if (mask_r[iu2x_pkg::SLOT_HORIZ]) begin
      sel[iu2x_pkg::SLOT_HORIZ] = 1'b1;
      pix_sel = run_r.horiz;
      col_sel = run_r.col_even - iu2x_pkg::OUT_COL_W'(1);
    end else begin
      sel[iu2x_pkg::SLOT_ORIG] = 1'b1;
    end
  end

  assign mask_nxt  = mask_r & ~sel;
  assign last      = (mask_nxt == '0);
  assign run_ready = !run_r.valid || (emit && last);
  assign load      = run_in.valid && run_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r.valid <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        run_r.valid    <= 1'b1;
        run_r.mask     <= run_in.mask;
        run_r.centre   <= run_in.centre;
        run_r.vert     <= run_in.vert;
        run_r.horiz    <= run_in.horiz;
        run_r.orig     <= run_in.orig;
        run_r.row_even <= run_in.row_even;
        run_r.col_even <= run_in.col_even;
      end else if (emit && last) begin
        run_r.valid <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mask_r <= run_in.mask;
    end else if (emit) begin
      mask_r <= mask_nxt;
    end
    if (emit) begin
      out_pix_r  <= pix_sel;
      out_row_r  <= row_sel;
      out_col_r  <= col_sel;
      out_last_r <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red         = out_pix_r.red;
  assign out_green       = out_pix_r.green;
  assign out_blue        = out_pix_r.blue;
  assign out_row         = out_row_r;
  assign out_col         = out_col_r;
  assign out_last_of_run = out_last_r;

  // the item's own pixel is always still pending while its run is held
  `IU2X_ASSERT_IMP(a_orig_pending, clk, rst_n, run_r.valid, mask_r[iu2x_pkg::SLOT_ORIG])
  // a result that is not the last one leaves the rest of its run behind
  `IU2X_ASSERT_IMP(a_run_behind, clk, rst_n, out_valid_r && !out_last_r, run_r.valid)
  // once started, a run goes out without gaps
  `IU2X_ASSERT_NXT(a_no_gap, clk, rst_n, out_valid_r && !out_stall && !out_last_r,
                   out_valid_r)

endmodule

>>> hw/rtl/image_upscale_2x_midpoint.sv
// Top level of the streaming 2x midpoint upscaler.
// Depends on iu2x_pkg, iu2x_ram, iu2x_front, iu2x_interp and iu2x_seq.
//
// Usage:
//   Input pixels of a W by H RGB image arrive in raster order on in_*;
//   an item is taken when in_valid is high and in_stall low.
//   Each input pixel causes one to four output pixels of the (2W-1) by (2H-1)
//   image on out_*, tagged with out_row/out_col; out_last_of_run marks the
//   final one of each input pixel. A result is taken when out_valid is high
//   and out_stall low.
//   Results pass the input, run and output registers in that order.
//   Throughput: one result per cycle through the single output register while
//   out_stall is low; an input pixel in the image interior gives four results.
//   The next pixel is taken while the current one's results are still going
//   out; the line store is read and written once per item at its column.
//   cfg_* writes image_width (index 0) and image_height (index 1); always
//   ready. Write them only while the block is idle.
//   Reset: sizes go to 1024 by 1024, counters to the image origin, all
//   valids clear. The line store is not cleared; row 0 ignores what it reads.
//   A stalled receiver holds the output; the block then fills its internal
//   stages and raises in_stall until results move again.
module image_upscale_2x_midpoint (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [iu2x_pkg::CHAN_W-1:0]          in_red,
  input  logic [iu2x_pkg::CHAN_W-1:0]          in_green,
  input  logic [iu2x_pkg::CHAN_W-1:0]          in_blue,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [iu2x_pkg::CHAN_W-1:0]          out_red,
  output logic [iu2x_pkg::CHAN_W-1:0]          out_green,
  output logic [iu2x_pkg::CHAN_W-1:0]          out_blue,
  output logic [iu2x_pkg::OUT_ROW_W-1:0]       out_row,
  output logic [iu2x_pkg::OUT_COL_W-1:0]       out_col,
  output logic                                 out_last_of_run,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [iu2x_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [iu2x_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [iu2x_pkg::WIDTH_REG_W-1:0]  width_r, width_eff;
  logic [iu2x_pkg::HEIGHT_REG_W-1:0] height_r, height_eff;
  logic                              front_take;
  logic                              run_ready;
  logic                              ram_en;
  logic [iu2x_pkg::COL_W-1:0]        ram_addr;
  iu2x_pkg::pixel_t                  ram_wdata;
  iu2x_pkg::pixel_t                  above;
  iu2x_pkg::front_t                  front;
  iu2x_pkg::run_t                    run_in;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= iu2x_pkg::WIDTH_REG_W'(iu2x_pkg::MAX_WIDTH);
      height_r <= iu2x_pkg::HEIGHT_REG_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == iu2x_pkg::CFG_IMAGE_WIDTH) begin
        width_r <= cfg_data[iu2x_pkg::WIDTH_REG_W-1:0];
      end else if (cfg_index == iu2x_pkg::CFG_IMAGE_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  // zero reads as one, oversize saturates
  always_comb begin
    if (width_r == '0) begin
      width_eff = iu2x_pkg::WIDTH_REG_W'(1);
    end else if (width_r > iu2x_pkg::WIDTH_REG_W'(iu2x_pkg::MAX_WIDTH)) begin
      width_eff = iu2x_pkg::WIDTH_REG_W'(iu2x_pkg::MAX_WIDTH);
    end else begin
      width_eff = width_r;
    end
    if (height_r == '0) begin
      height_eff = iu2x_pkg::HEIGHT_REG_W'(1);
    end else if (height_r > iu2x_pkg::HEIGHT_REG_W'(iu2x_pkg::MAX_HEIGHT)) begin
      height_eff = iu2x_pkg::HEIGHT_REG_W'(iu2x_pkg::MAX_HEIGHT);
    end else begin
      height_eff = height_r;
    end
  end

  iu2x_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .front_take (front_take),
    .ram_en     (ram_en),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .front      (front)
  );

  iu2x_ram #(
    .WIDTH ($bits(iu2x_pkg::pixel_t)),
    .DEPTH (iu2x_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_en),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (above)
  );

  iu2x_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .front      (front),
    .above      (above),
    .run_ready  (run_ready),
    .front_take (front_take),
    .run_in     (run_in)
  );

  iu2x_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .run_in          (run_in),
    .run_ready       (run_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run)
  );

endmodule

>>> tb/tb.sv
// Self-checking bench for image_upscale_2x_midpoint: a directed table, then random images.
// Each output pixel is checked against an in-bench model of the 2x midpoint enlargement.
// Depends on iu2x_pkg and the image_upscale_2x_midpoint RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 4;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 40;
  localparam int N_DIR       = 32;
  localparam logic [iu2x_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = '1;

  typedef enum logic [1:0] {DIR_PIX, DIR_LIT, DIR_CFG} dir_kind_t;

  // one row of the directed table; row/col hold the typed-in position for DIR_LIT
  typedef struct packed {
    dir_kind_t                       kind;
    logic [iu2x_pkg::CFG_IDX_W-1:0]  idx;
    logic [iu2x_pkg::CFG_DATA_W-1:0] data;
    iu2x_pkg::pixel_t                pix;
    logic [iu2x_pkg::OUT_ROW_W-1:0]  row;
    logic [iu2x_pkg::OUT_COL_W-1:0]  col;
  } dir_row_t;

  typedef struct packed {
    iu2x_pkg::pixel_t               pix;
    logic [iu2x_pkg::OUT_ROW_W-1:0] row;
    logic [iu2x_pkg::OUT_COL_W-1:0] col;
    logic                           last;
  } upscaled_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [iu2x_pkg::CHAN_W-1:0] in_red = '0;
  logic [iu2x_pkg::CHAN_W-1:0] in_green = '0;
  logic [iu2x_pkg::CHAN_W-1:0] in_blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [iu2x_pkg::CHAN_W-1:0] out_red;
  logic [iu2x_pkg::CHAN_W-1:0] out_green;
  logic [iu2x_pkg::CHAN_W-1:0] out_blue;
  logic [iu2x_pkg::OUT_ROW_W-1:0] out_row;
  logic [iu2x_pkg::OUT_COL_W-1:0] out_col;
  logic out_last_of_run;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [iu2x_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [iu2x_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // model of the block
  logic [iu2x_pkg::WIDTH_REG_W-1:0]  width_reg = iu2x_pkg::WIDTH_REG_W'(1024);
  logic [iu2x_pkg::HEIGHT_REG_W-1:0] height_reg = iu2x_pkg::HEIGHT_REG_W'(1024);
  iu2x_pkg::pixel_t prev_line [iu2x_pkg::MAX_WIDTH];
  bit               prev_line_set [iu2x_pkg::MAX_WIDTH];
  iu2x_pkg::pixel_t left_pix = '0;
  iu2x_pkg::pixel_t left_vmid = '0;
  int     col_pos = 0;
  int     row_pos = 0;

  upscaled_t upscaled_q [$];
  int  mismatches = 0;
  int  cycle_cnt = 0;
  int  send_idle = 0;
  int  stall_pct = 0;
  bit  cfg_open = 1'b0;

  int idle_send [4] = '{0, 88, 0, 18};
  int idle_recv [4] = '{0, 0, 88, 18};

  dir_row_t plan [N_DIR] = '{
    '{DIR_LIT, '0, '0, 24'h000000, 13'd0, 11'd0},
    '{DIR_PIX, '0, '0, 24'hffffff, '0, '0},
    '{DIR_PIX, '0, '0, 24'h01807f, '0, '0},
    '{DIR_CFG, CFG_IDX_SPARE, 13'h1fff, '0, '0, '0},
    // zero sizes act as 1: from the second pixel on, every pixel stands alone at the origin
    '{DIR_CFG, iu2x_pkg::CFG_IMAGE_WIDTH, 13'd0, '0, '0, '0},
    '{DIR_CFG, iu2x_pkg::CFG_IMAGE_HEIGHT, 13'd0, '0, '0, '0},
    '{DIR_PIX, '0, '0, 24'h123456, '0, '0},
    '{DIR_LIT, '0, '0, 24'hff00ff, 13'd0, 11'd0},
    '{DIR_LIT, '0, '0, 24'h00ff00, 13'd0, 11'd0},
    '{DIR_LIT, '0, '0, 24'haa55aa, 13'd0, 11'd0},
    '{DIR_LIT, '0, '0, 24'h55aa55, 13'd0, 11'd0},
    '{DIR_CFG, iu2x_pkg::CFG_IMAGE_WIDTH, 13'd3, '0, '0, '0},
    '{DIR_CFG, iu2x_pkg::CFG_IMAGE_HEIGHT, 13'd3, '0, '0, '0},
    '{DIR_PIX, '0, '0, 24'hffffff, '0, '0},
    '{DIR_PIX, '0, '0, 24'h000000, '0, '0},
    '{DIR_PIX, '0, '0, 24'h010101, '0, '0},
    '{DIR_PIX, '0, '0, 24'hfe0180, '0, '0},
    '{DIR_PIX, '0, '0, 24'h00ff7f, '0, '0},
    '{DIR_PIX, '0, '0, 24'hff0081, '0, '0},
    '{DIR_PIX, '0, '0, 24'h808080, '0, '0},
    '{DIR_PIX, '0, '0, 24'h7f8100, '0, '0},
    '{DIR_PIX, '0, '0, 24'hfffefd, '0, '0},
    '{DIR_LIT, '0, '0, 24'h3cc399, 13'd0, 11'd0},
    // oversize values saturate; written mid-row
    '{DIR_CFG, iu2x_pkg::CFG_IMAGE_WIDTH, 13'h1fff, '0, '0, '0},
    '{DIR_CFG, iu2x_pkg::CFG_IMAGE_HEIGHT, 13'h1fff, '0, '0, '0},
    '{DIR_PIX, '0, '0, 24'h112233, '0, '0},
    '{DIR_PIX, '0, '0, 24'h445566, '0, '0},
    // column counter already past the new width: wraps on the next item
    '{DIR_CFG, iu2x_pkg::CFG_IMAGE_WIDTH, 13'd2, '0, '0, '0},
    '{DIR_CFG, iu2x_pkg::CFG_IMAGE_HEIGHT, 13'd2, '0, '0, '0},
    '{DIR_PIX, '0, '0, 24'h778899, '0, '0},
    '{DIR_PIX, '0, '0, 24'h0f1e2d, '0, '0},
    '{DIR_PIX, '0, '0, 24'hf0e1d2, '0, '0}
  };

  image_upscale_2x_midpoint uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int fit(int v, int top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic iu2x_pkg::pixel_t blend(iu2x_pkg::pixel_t a, iu2x_pkg::pixel_t b);
    logic [iu2x_pkg::CHAN_W:0] sr, sg, sb;
    sr = a.red + b.red;
    sg = a.green + b.green;
    sb = a.blue + b.blue;
    return {sr[iu2x_pkg::CHAN_W:1], sg[iu2x_pkg::CHAN_W:1], sb[iu2x_pkg::CHAN_W:1]};
  endfunction

  function automatic upscaled_t spot(iu2x_pkg::pixel_t p, int r, int c);
    return '{pix: p, row: iu2x_pkg::OUT_ROW_W'(r), col: iu2x_pkg::OUT_COL_W'(c),
             last: 1'b0};
  endfunction

  // works out the output pixels of one accepted input pixel and advances the model
  function automatic void upscale_pixel(iu2x_pkg::pixel_t p, bit keep);
    int w, h, k, i;
    iu2x_pkg::pixel_t vmid;
    upscaled_t res [$];
    w = fit(int'(width_reg), iu2x_pkg::MAX_WIDTH);
    h = fit(int'(height_reg), iu2x_pkg::MAX_HEIGHT);
    k = col_pos;
    i = row_pos;
    vmid = '0;
    if (i >= 1) begin
      vmid = blend(prev_line[k], p);
      if (k >= 1) res.push_back(spot(blend(left_vmid, vmid), 2 * i - 1, 2 * k - 1));
      res.push_back(spot(vmid, 2 * i - 1, 2 * k));
    end
    if (k >= 1) res.push_back(spot(blend(left_pix, p), 2 * i, 2 * k - 1));
    res.push_back(spot(p, 2 * i, 2 * k));
    res[res.size() - 1].last = 1'b1;
    if (keep) foreach (res[j]) upscaled_q.push_back(res[j]);
    prev_line[k] = p;
    prev_line_set[k] = 1'b1;
    left_pix = p;
    left_vmid = vmid;
    k++;
    if (k >= w) begin
      k = 0;
      i++;
      if (i >= h) i = 0;
    end
    col_pos = k;
    row_pos = i;
  endfunction

  // a width the line store can serve: rows past the first read back every column
  function automatic logic [iu2x_pkg::CFG_DATA_W-1:0] safe_width(
      logic [iu2x_pkg::CFG_DATA_W-1:0] d);
    int n;
    n = 0;
    if (row_pos == 0) return d;
    while (n < iu2x_pkg::MAX_WIDTH && prev_line_set[n]) n++;
    if (fit(int'(d[iu2x_pkg::WIDTH_REG_W-1:0]), iu2x_pkg::MAX_WIDTH) <= n) return d;
    return iu2x_pkg::CFG_DATA_W'(n);
  endfunction

  function automatic iu2x_pkg::pixel_t rand_pixel();
    iu2x_pkg::pixel_t p;
    p = iu2x_pkg::pixel_t'($urandom);
    case ($urandom_range(7))
      0: p = '0;
      1: p = '1;
      2: p = left_pix ^ 24'h010101;
      3: p.green = ~p.red;
      default: ;
    endcase
    return p;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic drain(bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (upscaled_q.size() != 0);
    if (settle) repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_put(logic [iu2x_pkg::CFG_IDX_W-1:0] idx,
                         logic [iu2x_pkg::CFG_DATA_W-1:0] data);
    if (!cfg_open) begin
      drain(1'b1);
      cfg_open = 1'b1;
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == iu2x_pkg::CFG_IMAGE_WIDTH)
      width_reg = data[iu2x_pkg::WIDTH_REG_W-1:0];
    else if (idx == iu2x_pkg::CFG_IMAGE_HEIGHT)
      height_reg = data[iu2x_pkg::HEIGHT_REG_W-1:0];
  endtask

  task automatic send_pixel(iu2x_pkg::pixel_t p, bit keep);
    if (cfg_open) begin
      cfg_valid <= 1'b0;
      cfg_open = 1'b0;
    end
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1'b1;
    in_red <= p.red;
    in_green <= p.green;
    in_blue <= p.blue;
    do @(posedge clk); while (in_stall !== 1'b0);
    upscale_pixel(p, keep);
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    upscaled_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (upscaled_q.size() == 0) begin
        $error("unexpected output pixel at row %0d col %0d", out_row, out_col);
        mismatches++;
      end else begin
        want = upscaled_q.pop_front();
        check_field("out_red", want.pix.red, out_red);
        check_field("out_green", want.pix.green, out_green);
        check_field("out_blue", want.pix.blue, out_blue);
        check_field("out_row", want.row, out_row);
        check_field("out_col", want.col, out_col);
        check_field("out_last_of_run", want.last, out_last_of_run);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("image_upscale_2x_midpoint regression: fail");
      $finish;
    end
  end

  initial begin
    int r;
    int wv;
    int hv;
    logic [iu2x_pkg::CFG_DATA_W-1:0] wdata;
    logic [iu2x_pkg::CFG_DATA_W-1:0] hdata;
    bit width_first;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 18;
    stall_pct = 18;
    foreach (plan[j]) begin
      case (plan[j].kind)
        DIR_CFG: cfg_put(plan[j].idx, plan[j].data);
        DIR_PIX: send_pixel(plan[j].pix, 1'b1);
        default: begin
          send_pixel(plan[j].pix, 1'b0);
          upscaled_q.push_back('{pix: plan[j].pix, row: plan[j].row, col: plan[j].col,
                                 last: 1'b1});
        end
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle = idle_send[ph % 4];
      stall_pct = idle_recv[ph % 4];
      r = $urandom_range(99);
      if (r < 6) wv = 0;
      else if (r < 12) wv = $urandom_range(1025, 2047);
      else if (r < 16) wv = iu2x_pkg::MAX_WIDTH;
      else if (r < 30) wv = $urandom_range(7, 40);
      else wv = $urandom_range(1, 6);
      r = $urandom_range(99);
      if (r < 6) hv = 0;
      else if (r < 12) hv = $urandom_range(4097, 8191);
      else if (r < 16) hv = iu2x_pkg::MAX_HEIGHT;
      else if (r < 30) hv = $urandom_range(7, 20);
      else hv = $urandom_range(1, 5);
      // upper data bits are dropped by the width register
      wdata = safe_width({2'($urandom_range(3)), 11'(wv)});
      hdata = iu2x_pkg::CFG_DATA_W'(hv);
      width_first = $urandom_range(1);
      if (width_first && $urandom_range(3) != 0) cfg_put(iu2x_pkg::CFG_IMAGE_WIDTH, wdata);
      if ($urandom_range(99) < 15)
        cfg_put(iu2x_pkg::CFG_IDX_W'($urandom_range(2, 15)),
                iu2x_pkg::CFG_DATA_W'($urandom));
      if ($urandom_range(3) != 0) cfg_put(iu2x_pkg::CFG_IMAGE_HEIGHT, hdata);
      if (!width_first && $urandom_range(3) != 0)
        cfg_put(iu2x_pkg::CFG_IMAGE_WIDTH, safe_width(wdata));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && (ph == 0 || $urandom_range(1))) drain(1'b0);
        send_pixel(rand_pixel(), 1'b1);
      end
    end

    drain(1'b1);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && upscaled_q.size() == 0)
      $display("image_upscale_2x_midpoint regression: pass");
    else
      $display("image_upscale_2x_midpoint regression: fail");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/iu2x_pkg.sv
hw/rtl/iu2x_ram.sv
hw/rtl/iu2x_front.sv
hw/rtl/iu2x_interp.sv
hw/rtl/iu2x_seq.sv
hw/rtl/image_upscale_2x_midpoint.sv
tb/tb.sv
